/* hw/rtl/hex_word_packer_macros.svh */
// Assertion macros for the hex word packer RTL.
// Depends on nothing; files that assert take it by include.
`ifndef HEX_WORD_PACKER_MACROS_SVH
`define HEX_WORD_PACKER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define HWP_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define HWP_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/hwp_pkg.sv */
// Shared types, constants and character helpers for the hex word packer.
// Depends on nothing; used by every module of the block.
package hwp_pkg;

    localparam int CNT_W           = 6;
    localparam int CHAR_W          = 8;
    localparam int LEN_W           = 16;
    localparam int NIB_W           = 4;
    localparam int MAX_WORD_DEF    = 62;
    localparam int JOB_Q_CNT_W     = 2;
    localparam int CFG_IDX_W       = 1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ADAPTIVE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_TERM     = 1'b1;

    localparam logic              ADAPTIVE_RST = 1'b1;
    localparam logic [CHAR_W-1:0] TERM_RST     = 8'h00;

    localparam logic [CHAR_W-1:0] CH_0 = 8'h30;
    localparam logic [CHAR_W-1:0] CH_9 = 8'h39;
    localparam logic [CHAR_W-1:0] CH_A = 8'h41;
    localparam logic [CHAR_W-1:0] CH_F = 8'h46;
    // Offset that maps 'A' onto ten.
    localparam logic [CHAR_W-1:0] CH_A_OFS = 8'h37;

    // One finished word waiting to be sent out.
    typedef struct packed {
        logic              raw;
        logic              bank;
        logic [CNT_W-1:0]  count;
        logic [CHAR_W-1:0] term;
    } job_t;

    typedef struct packed {
        logic valid;
        job_t job;
    } job_push_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_HEAD,
        B_RD_HI,
        B_RD_LO,
        B_PACK,
        B_RD_RAW,
        B_RAW,
        B_TERM
    } back_state_t;

    function automatic logic is_hex_char(input logic [CHAR_W-1:0] c);
        is_hex_char = ((c >= CH_0) && (c <= CH_9)) || ((c >= CH_A) && (c <= CH_F));
    endfunction

    function automatic logic [NIB_W-1:0] nibble_of(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] d;
        d = '0;
        if ((c >= CH_0) && (c <= CH_9))
        begin
            d = c - CH_0;
        end
        else if ((c >= CH_A) && (c <= CH_F))
        begin
            d = c - CH_A_OFS;
        end
        nibble_of = d[NIB_W-1:0];
    endfunction

endpackage

/* hw/rtl/hwp_word_ram.sv */
// Two-bank word store: one bank fills while the other is read out.
// Depends on hwp_pkg.
module hwp_word_ram
    import hwp_pkg::*;
#(
    parameter int MAX_WORD_CHARS = MAX_WORD_DEF
)
(
    input  logic                                   clk,
    input  logic                                   wr_en,
    input  logic                                   wr_bank,
    input  logic [$clog2(MAX_WORD_CHARS)-1:0]      wr_idx,
    input  logic [CHAR_W-1:0]                      wr_data,
    input  logic                                   rd_en,
    input  logic                                   rd_bank,
    input  logic [$clog2(MAX_WORD_CHARS)-1:0]      rd_idx,
    output logic [CHAR_W-1:0]                      rd_data
);

    logic [CHAR_W-1:0] mem [0:1][0:MAX_WORD_CHARS-1];
    logic [CHAR_W-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_bank][wr_idx] <= wr_data;
        end
    end

    // Registered read port; data holds when no read is issued.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_bank][rd_idx];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* hw/rtl/hwp_front.sv */
// Front end: takes characters, fills the word store and classifies each word at its end.
// Depends on hwp_pkg.
module hwp_front
    import hwp_pkg::*;
#(
    parameter int MAX_WORD_CHARS = MAX_WORD_DEF
)
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic [CHAR_W-1:0]                      char_in,
    input  logic                                   end_of_buffer,
    input  logic                                   adaptive_mode,
    input  logic [CHAR_W-1:0]                      terminator_char,
    input  logic [JOB_Q_CNT_W-1:0]                 q_count,
    input  logic                                   back_busy,
    output job_push_t                              push,
    output logic                                   wr_en,
    output logic                                   wr_bank,
    output logic [$clog2(MAX_WORD_CHARS)-1:0]      wr_idx,
    output logic [CHAR_W-1:0]                      wr_data
);

    localparam int IDX_W = $clog2(MAX_WORD_CHARS);

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             all_hex_reg, all_hex_next;
    logic             ovf_reg, ovf_next;
    logic             bank_reg, bank_next;

    logic             accept;
    logic             is_term;
    logic             store_ok;
    logic [CNT_W-1:0] cnt_upd;
    logic             hex_upd;
    logic             ovf_upd;
    logic             word_end;
    logic             hex_path;
    logic [JOB_Q_CNT_W:0] outstanding;

    // At most one word may be in flight, so the bank being filled is never read.
    assign outstanding = {1'b0, q_count} + {{JOB_Q_CNT_W{1'b0}}, back_busy};
    assign in_ready    = (outstanding <= (JOB_Q_CNT_W+1)'(1));
    assign accept      = in_valid && in_ready;

    // Word state after this character.
    assign is_term  = (char_in == terminator_char);
    assign store_ok = (cnt_reg < CNT_W'(MAX_WORD_CHARS));
    assign cnt_upd  = (is_term || !store_ok) ? cnt_reg : cnt_reg + CNT_W'(1);
    assign hex_upd  = is_term ? all_hex_reg : (all_hex_reg && is_hex_char(char_in));
    assign ovf_upd  = is_term ? ovf_reg : (ovf_reg || !store_ok);
    assign word_end = accept && (is_term || end_of_buffer);
    assign hex_path = hex_upd || !adaptive_mode;

    // Odd hex words and overflowed words produce no job.
    always_comb
    begin
        push.valid     = word_end && !ovf_upd && (!hex_path || !cnt_upd[0]);
        push.job.raw   = !hex_path;
        push.job.bank  = bank_reg;
        push.job.count = cnt_upd;
        push.job.term  = terminator_char;
    end

    // Store write.
    assign wr_en   = accept && !is_term && store_ok;
    assign wr_bank = bank_reg;
    assign wr_idx  = cnt_reg[IDX_W-1:0];
    assign wr_data = char_in;

    always_comb
    begin
        cnt_next     = cnt_reg;
        all_hex_next = all_hex_reg;
        ovf_next     = ovf_reg;
        bank_next    = bank_reg;
        if (word_end)
        begin
            cnt_next     = '0;
            all_hex_next = 1'b1;
            ovf_next     = 1'b0;
            bank_next    = bank_reg ^ push.valid;
        end
        else if (accept)
        begin
            cnt_next     = cnt_upd;
            all_hex_next = hex_upd;
            ovf_next     = ovf_upd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg     <= '0;
            all_hex_reg <= 1'b1;
            ovf_reg     <= 1'b0;
            bank_reg    <= 1'b0;
        end
        else
        begin
            cnt_reg     <= cnt_next;
            all_hex_reg <= all_hex_next;
            ovf_reg     <= ovf_next;
            bank_reg    <= bank_next;
        end
    end

endmodule

/* hw/rtl/hwp_job_fifo.sv */
// Two-entry queue of finished words between the front and back ends.
// Depends on hwp_pkg and hex_word_packer_macros.svh.
`include "hex_word_packer_macros.svh"
module hwp_job_fifo
    import hwp_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  job_push_t               push,
    input  logic                    pop,
    output job_t                    head,
    output logic                    empty,
    output logic [JOB_Q_CNT_W-1:0]  count
);

    job_t                   entry_reg [0:1];
    logic                   wr_ptr_reg, wr_ptr_next;
    logic                   rd_ptr_reg, rd_ptr_next;
    logic [JOB_Q_CNT_W-1:0] cnt_reg, cnt_next;

    assign head  = entry_reg[rd_ptr_reg];
    assign empty = (cnt_reg == '0);
    assign count = cnt_reg;

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push.valid;
        rd_ptr_next = rd_ptr_reg ^ pop;
        cnt_next    = cnt_reg;
        if (push.valid && !pop)
        begin
            cnt_next = cnt_reg + JOB_Q_CNT_W'(1);
        end
        else if (pop && !push.valid)
        begin
            cnt_next = cnt_reg - JOB_Q_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push.valid)
        begin
            entry_reg[wr_ptr_reg] <= push.job;
        end
    end

    `HWP_ASSERT_IMP(a_no_push_full, clk, rst_n, push.valid, cnt_reg != JOB_Q_CNT_W'(2), "job pushed into full queue")
    `HWP_ASSERT_IMP(a_no_pop_empty, clk, rst_n, pop, cnt_reg != '0, "job popped from empty queue")
    `HWP_ASSERT_NXT(a_count_up, clk, rst_n, push.valid && !pop, cnt_reg == $past(cnt_reg) + JOB_Q_CNT_W'(1), "queue count did not rise on push")

endmodule

/* hw/rtl/hwp_back.sv */
// Back end: reads a finished word from the store and sends its output bytes.
// Depends on hwp_pkg.
module hwp_back
    import hwp_pkg::*;
#(
    parameter int MAX_WORD_CHARS = MAX_WORD_DEF
)
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  job_t                                   head,
    input  logic                                   q_empty,
    output logic                                   pop,
    output logic                                   busy,
    output logic                                   rd_en,
    output logic                                   rd_bank,
    output logic [$clog2(MAX_WORD_CHARS)-1:0]      rd_idx,
    input  logic [CHAR_W-1:0]                      rd_data,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic [CHAR_W-1:0]                      out_byte,
    output logic                                   last_of_word,
    output logic [LEN_W-1:0]                       total_length
);

    localparam int IDX_W = $clog2(MAX_WORD_CHARS);

    back_state_t       state_reg, state_next;
    job_t              job_reg;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic [NIB_W-1:0]  hi_reg;
    logic              out_valid_reg;
    logic [CHAR_W-1:0] out_byte_reg;
    logic              out_last_reg;
    logic [LEN_W-1:0]  emitted_reg;

    logic              out_free;
    logic              load;
    logic              latch_hi;
    logic [CHAR_W-1:0] byte_d;
    logic              last_d;
    logic [CNT_W-1:0]  idx_p1;
    logic [CNT_W-1:0]  idx_p2;

    assign out_free = !out_valid_reg || out_ready;
    assign idx_p1   = idx_reg + CNT_W'(1);
    assign idx_p2   = idx_reg + CNT_W'(2);
    assign busy     = (state_reg != B_IDLE);
    assign rd_bank  = job_reg.bank;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE:
            begin
                if (!q_empty)
                begin
                    state_next = B_HEAD;
                end
            end
            B_HEAD:
            begin
                if (out_free)
                begin
                    if (job_reg.count == '0)
                    begin
                        state_next = job_reg.raw ? B_TERM : B_IDLE;
                    end
                    else
                    begin
                        state_next = job_reg.raw ? B_RD_RAW : B_RD_HI;
                    end
                end
            end
            B_RD_HI:  state_next = B_RD_LO;
            B_RD_LO:  state_next = B_PACK;
            B_PACK:
            begin
                if (out_free)
                begin
                    state_next = (idx_p2 == job_reg.count) ? B_IDLE : B_RD_HI;
                end
            end
            B_RD_RAW: state_next = B_RAW;
            B_RAW:
            begin
                if (out_free)
                begin
                    state_next = (idx_p1 == job_reg.count) ? B_TERM : B_RD_RAW;
                end
            end
            B_TERM:
            begin
                if (out_free)
                begin
                    state_next = B_IDLE;
                end
            end
            default:  state_next = B_IDLE;
        endcase
    end

    // State outputs.
    always_comb
    begin
        pop      = 1'b0;
        load     = 1'b0;
        latch_hi = 1'b0;
        rd_en    = 1'b0;
        rd_idx   = idx_reg[IDX_W-1:0];
        byte_d   = rd_data;
        last_d   = 1'b0;
        idx_next = idx_reg;
        case (state_reg)
            B_IDLE:
            begin
                pop      = !q_empty;
                idx_next = '0;
            end
            B_HEAD:
            begin
                load   = out_free;
                byte_d = job_reg.raw ? '0 : CHAR_W'(job_reg.count[CNT_W-1:1]);
                last_d = !job_reg.raw && (job_reg.count == '0);
            end
            B_RD_HI:
            begin
                rd_en = 1'b1;
            end
            B_RD_LO:
            begin
                latch_hi = 1'b1;
                rd_en    = 1'b1;
                rd_idx   = idx_p1[IDX_W-1:0];
            end
            B_PACK:
            begin
                load   = out_free;
                byte_d = {hi_reg, nibble_of(rd_data)};
                last_d = (idx_p2 == job_reg.count);
                if (out_free)
                begin
                    idx_next = idx_p2;
                end
            end
            B_RD_RAW:
            begin
                rd_en = 1'b1;
            end
            B_RAW:
            begin
                load = out_free;
                if (out_free)
                begin
                    idx_next = idx_p1;
                end
            end
            B_TERM:
            begin
                load   = out_free;
                byte_d = job_reg.term;
                last_d = 1'b1;
            end
            default:
            begin
                pop = 1'b0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
            emitted_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (load)
            begin
                out_valid_reg <= 1'b1;
                emitted_reg   <= emitted_reg + LEN_W'(1);
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        if (pop)
        begin
            job_reg <= head;
        end
        if (latch_hi)
        begin
            hi_reg <= nibble_of(rd_data);
        end
        if (load)
        begin
            out_byte_reg <= byte_d;
            out_last_reg <= last_d;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_byte     = out_byte_reg;
    assign last_of_word = out_last_reg;
    assign total_length = emitted_reg;

endmodule

/* hw/rtl/hex_word_packer.sv */
// Top level of the hex word packer: configuration registers and the front/queue/back chain.
// Depends on hwp_pkg, hwp_word_ram, hwp_front, hwp_job_fifo and hwp_back.
//
// Channel  | Direction | Contents
// s_axis   | request in  | tdata[7:0] char_in, tlast end_of_buffer
// m_axis   | request out | tdata[7:0] out_byte, tdata[23:8] total_length, tlast last_of_word
// cfg      | write in    | cfg_addr 0 adaptive_mode, 1 terminator_char
//
// A character is taken while s_axis_tready is high; up to one finished word may wait while the next fills.
// The back end sends a header byte, then packed bytes, each from two reads of the single store read
// port (B_RD_HI, B_RD_LO, B_PACK), or raw characters, each read then sent, and for raw words a terminator byte.
// Reset clears the word state, queue, output register and byte total; no clearing pass.
// An output stall holds the back end; the front end stalls once a second word is waiting.
module hex_word_packer
    import hwp_pkg::*;
#(
    parameter int MAX_WORD_CHARS = MAX_WORD_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [7:0]            s_axis_tdata,   // [7:0] char_in
    input  logic                  s_axis_tlast,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [23:0]           m_axis_tdata,   // [7:0] out_byte, [23:8] total_length
    output logic                  m_axis_tlast,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_addr,
    input  logic [CHAR_W-1:0]     cfg_data
);

    localparam int IDX_W = $clog2(MAX_WORD_CHARS);

    logic              adaptive_reg;
    logic [CHAR_W-1:0] term_reg;

    job_push_t              push;
    job_t                   head;
    logic                   q_empty;
    logic [JOB_Q_CNT_W-1:0] q_count;
    logic                   pop;
    logic                   back_busy;
    logic                   wr_en;
    logic                   wr_bank;
    logic [IDX_W-1:0]       wr_idx;
    logic [CHAR_W-1:0]      wr_data;
    logic                   rd_en;
    logic                   rd_bank;
    logic [IDX_W-1:0]       rd_idx;
    logic [CHAR_W-1:0]      rd_data;
    logic [CHAR_W-1:0]      out_byte;
    logic [LEN_W-1:0]       total_length;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            adaptive_reg <= ADAPTIVE_RST;
            term_reg     <= TERM_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_ADAPTIVE: adaptive_reg <= cfg_data[0];
                REG_TERM:     term_reg     <= cfg_data;
                default:      term_reg     <= term_reg;
            endcase
        end
    end

    hwp_word_ram #(.MAX_WORD_CHARS(MAX_WORD_CHARS)) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_bank (wr_bank),
        .wr_idx  (wr_idx),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_bank (rd_bank),
        .rd_idx  (rd_idx),
        .rd_data (rd_data)
    );

    hwp_front #(.MAX_WORD_CHARS(MAX_WORD_CHARS)) u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (s_axis_tvalid),
        .in_ready        (s_axis_tready),
        .char_in         (s_axis_tdata),
        .end_of_buffer   (s_axis_tlast),
        .adaptive_mode   (adaptive_reg),
        .terminator_char (term_reg),
        .q_count         (q_count),
        .back_busy       (back_busy),
        .push            (push),
        .wr_en           (wr_en),
        .wr_bank         (wr_bank),
        .wr_idx          (wr_idx),
        .wr_data         (wr_data)
    );

    hwp_job_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (pop),
        .head  (head),
        .empty (q_empty),
        .count (q_count)
    );

    hwp_back #(.MAX_WORD_CHARS(MAX_WORD_CHARS)) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .q_empty      (q_empty),
        .pop          (pop),
        .busy         (back_busy),
        .rd_en        (rd_en),
        .rd_bank      (rd_bank),
        .rd_idx       (rd_idx),
        .rd_data      (rd_data),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .out_byte     (out_byte),
        .last_of_word (m_axis_tlast),
        .total_length (total_length)
    );

    assign m_axis_tdata = {total_length, out_byte};

endmodule
